// File: rtl/core/ufp_pkg.sv
// ----------------------------------------------------------------------------
// ufp_pkg
// Shared types and constants for the UART command frame parser: framing
// characters, keyword table and command codes.
// ----------------------------------------------------------------------------
package ufp_pkg;

  localparam int COMMAND_MAX_DEF = 32;
  localparam int MAX_DATA_DEF    = 64;

  localparam logic [7:0] CH_SEP = 8'h21;  // '!'
  localparam logic [7:0] CH_END = 8'h25;  // '%'

  localparam int NUM_KEYS   = 5;
  localparam int KW_MAX_LEN = 10;

  typedef logic [2:0] cmd_code_t;

  localparam cmd_code_t CODE_ERR    = 3'd0;
  localparam cmd_code_t CODE_COLOR  = 3'd1;
  localparam cmd_code_t CODE_RANDOM = 3'd2;
  localparam cmd_code_t CODE_SOLVE  = 3'd3;
  localparam cmd_code_t CODE_CUBE   = 3'd4;
  localparam cmd_code_t CODE_CHANGE = 3'd5;

  // Keyword k maps to command code k + 1, tested in ascending order.
  localparam cmd_code_t KW_CODE [NUM_KEYS] = '{
    CODE_COLOR, CODE_RANDOM, CODE_SOLVE, CODE_CUBE, CODE_CHANGE
  };

  localparam logic [5:0] KW_LEN [NUM_KEYS] = '{6'd10, 6'd6, 6'd5, 6'd9, 6'd6};

  localparam logic [7:0] KW_TEXT [NUM_KEYS][KW_MAX_LEN] = '{
    '{"r", "e", "a", "d", "_", "c", "o", "l", "o", "r"},
    '{"r", "a", "n", "d", "o", "m", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "o", "l", "v", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "e", "n", "d", "_", "c", "u", "b", "e", 8'h00},
    '{"c", "h", "a", "n", "g", "e", 8'h00, 8'h00, 8'h00, 8'h00}
  };

endpackage

// File: rtl/core/uart_command_frame_parser.sv
// ----------------------------------------------------------------------------
// uart_command_frame_parser
// Parses a byte stream into frames: skips the start byte, matches the command
// against five keywords, emits payload bytes with their index and one end
// result with the command code at the terminator.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in_     | input     | in_valid / in_ready | in_rx_byte
//  out_    | output    | out_valid/out_ready | out_frame_end, out_data_byte,
//          |           |                     | out_data_index, out_command_code,
//          |           |                     | out_overflow
//
//  One byte per cycle sustained while out_ready holds; a result passes
//  through the input register, then parse logic into the output register.
//  Synchronous active-low reset clears the frame state and both valid flags.
//  A stalled output holds the parse stage; the input register still takes a
//  byte while the parse stage is empty or advancing.
// ----------------------------------------------------------------------------
module uart_command_frame_parser #(
  parameter int COMMAND_MAX = ufp_pkg::COMMAND_MAX_DEF,
  parameter int MAX_DATA    = ufp_pkg::MAX_DATA_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_frame_end,
  output logic [7:0]        out_data_byte,
  output logic [5:0]        out_data_index,
  output ufp_pkg::cmd_code_t out_command_code,
  output logic              out_overflow
);
  import ufp_pkg::*;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_CMD   = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;

  localparam logic [5:0] CmdMaxC  = 6'(COMMAND_MAX);
  localparam logic [6:0] MaxDataC = 7'(MAX_DATA);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  // frame state
  logic [1:0]          phase_r, phase_nxt;
  logic [5:0]          cmd_pos_r, cmd_pos_nxt;
  logic [NUM_KEYS-1:0] match_r, match_nxt;
  logic [6:0]          data_cnt_r, data_cnt_nxt;
  logic                ovf_r, ovf_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic       frame_end_r, frame_end_nxt;
  logic [7:0] data_byte_r, data_byte_nxt;
  logic [5:0] data_index_r, data_index_nxt;
  cmd_code_t  code_r, code_nxt;
  logic       ovf_out_r, ovf_out_nxt;

  logic      s2_adv;
  logic      s2_fire;
  logic      in_xfer;
  cmd_code_t code_dec;

  assign s2_adv   = !out_valid_r || out_ready;
  assign s2_fire  = s1_valid_r && s2_adv;
  assign in_ready = !s1_valid_r || s2_adv;
  assign in_xfer  = in_valid && in_ready;

  assign s1_valid_nxt = in_xfer ? 1'b1 : (s2_fire ? 1'b0 : s1_valid_r);

  // first still-matching keyword of sufficient length wins
  always_comb begin
    code_dec = CODE_ERR;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (match_r[k] && (cmd_pos_r >= KW_LEN[k])) begin
        code_dec = KW_CODE[k];
      end
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    cmd_pos_nxt    = cmd_pos_r;
    match_nxt      = match_r;
    data_cnt_nxt   = data_cnt_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    frame_end_nxt  = frame_end_r;
    data_byte_nxt  = data_byte_r;
    data_index_nxt = data_index_r;
    code_nxt       = code_r;
    ovf_out_nxt    = ovf_out_r;

    if (s2_fire) begin
      unique case (phase_r)
        PH_CMD: begin
          if (s1_byte_r == CH_SEP) begin
            phase_nxt = PH_DATA;
          end else if (cmd_pos_r >= CmdMaxC) begin
            ovf_nxt = 1'b1;
          end else begin
            for (int k = 0; k < NUM_KEYS; k++) begin
              if ((cmd_pos_r < KW_LEN[k]) &&
                  (KW_TEXT[k][cmd_pos_r[3:0]] != s1_byte_r)) begin
                match_nxt[k] = 1'b0;
              end
            end
            cmd_pos_nxt = cmd_pos_r + 6'd1;
          end
        end
        PH_DATA: begin
          if (s1_byte_r == CH_SEP) begin
            // drop separator inside payload
          end else if (s1_byte_r == CH_END) begin
            out_valid_nxt  = 1'b1;
            frame_end_nxt  = 1'b1;
            data_byte_nxt  = 8'd0;
            data_index_nxt = 6'd0;
            code_nxt       = code_dec;
            ovf_out_nxt    = ovf_r;
            phase_nxt      = PH_START;
          end else if (data_cnt_r >= MaxDataC) begin
            ovf_nxt = 1'b1;
          end else begin
            out_valid_nxt  = 1'b1;
            frame_end_nxt  = 1'b0;
            data_byte_nxt  = s1_byte_r;
            data_index_nxt = data_cnt_r[5:0];
            code_nxt       = CODE_ERR;
            ovf_out_nxt    = ovf_r;
            data_cnt_nxt   = data_cnt_r + 7'd1;
          end
        end
        default: begin
          // start byte: skip it and open a new frame
          phase_nxt    = PH_CMD;
          cmd_pos_nxt  = 6'd0;
          match_nxt    = '1;
          data_cnt_nxt = 7'd0;
          ovf_nxt      = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_START;
      cmd_pos_r   <= 6'd0;
      match_r     <= '1;
      data_cnt_r  <= 7'd0;
      ovf_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      cmd_pos_r   <= cmd_pos_nxt;
      match_r     <= match_nxt;
      data_cnt_r  <= data_cnt_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_rx_byte;
    end
    frame_end_r  <= frame_end_nxt;
    data_byte_r  <= data_byte_nxt;
    data_index_r <= data_index_nxt;
    code_r       <= code_nxt;
    ovf_out_r    <= ovf_out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_frame_end    = frame_end_r;
  assign out_data_byte    = data_byte_r;
  assign out_data_index   = data_index_r;
  assign out_command_code = code_r;
  assign out_overflow     = ovf_out_r;

endmodule
